/* sv/digamma_evaluator_top_assert.svh */
// ----------------------------------------------------------------------------
// Digamma evaluator assertion macros
// Shared concurrent assertion forms for the digamma evaluator.
// ----------------------------------------------------------------------------
`ifndef DIGAMMA_EVALUATOR_TOP_ASSERT_SVH
`define DIGAMMA_EVALUATOR_TOP_ASSERT_SVH

// Same-cycle implication
`define DGEV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DGEV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/dgev_pkg.sv */
// ----------------------------------------------------------------------------
// Digamma evaluator package
// Constants, series coefficients and shared types.
// ----------------------------------------------------------------------------
package dgev_pkg;

  // ln 2 in Q.32
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } dgev_div_stat_t;

  // asymptotic series coefficients, Q.32, lowest order first
  function automatic logic signed [33:0] series_coef(input logic [2:0] k);
    logic signed [33:0] c;
    case (k)
      3'd0: c = -34'sd357913941;
      3'd1: c = 34'sd35791394;
      3'd2: c = -34'sd17043521;
      3'd3: c = 34'sd17895697;
      3'd4: c = -34'sd32537631;
      3'd5: c = 34'sd90592869;
      3'd6: c = -34'sd357913941;
      default: c = 34'sd1903786361;
    endcase
    return c;
  endfunction

endpackage

/* sv/dgev_mul.sv */
// ----------------------------------------------------------------------------
// Digamma evaluator multiplier
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module dgev_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  // product register, no reset needed
  always_ff @(posedge clk) begin
    prod <= 64'(a) * 64'(b);
  end

endmodule

/* sv/dgev_div.sv */
// ----------------------------------------------------------------------------
// Digamma evaluator divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dgev_div #(
  parameter int NW = 49
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [NW-1:0]           num,
  input  logic [31:0]             den,
  output logic [NW-1:0]           quo,
  output dgev_pkg::dgev_div_stat_t stat
);
  import dgev_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [31:0]   rem;
  logic [31:0]   dreg;
  logic [CW-1:0] cnt;
  logic [32:0]   trial;
  logic          fit;

  // trial subtract
  assign trial = {rem, quo[NW-1]};
  assign fit   = trial >= {1'b0, dreg};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= CW'(NW);
      end else if (stat.busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient shifts in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= num;
      rem  <= '0;
      dreg <= den;
    end else if (stat.busy) begin
      rem <= fit ? 32'(trial - {1'b0, dreg}) : trial[31:0];
      quo <= {quo[NW-2:0], fit};
    end
  end

endmodule

/* sv/digamma_evaluator_top.sv */
// ----------------------------------------------------------------------------
// Digamma evaluator
// psi(x) in Q16.16 by recurrence, iterative log and asymptotic series.
// ----------------------------------------------------------------------------
// Channel | Direction | Payload
// s_*     | in        | tdata[31:0] arg_value
// m_*     | out       | tdata[31:0] psi_value, tuser[0] saturated, tuser[1] invalid_arg
//
// One word at a time; s_tready is high only while the sequencer is idle.
// A zero argument skips the evaluation and is output as zero, flagged invalid_arg.
// A finished word waits in the output register; m_tready low stalls only
// the final load. Synchronous reset.
module digamma_evaluator_top #(
  parameter int FRAC_BITS   = 16,
  parameter int SHIFT_LIMIT = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] arg_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] psi_value
  output logic [1:0]  m_tuser    // [0] saturated, [1] invalid_arg
);
  import dgev_pkg::*;

  localparam int          NW    = 33 + FRAC_BITS;
  localparam int          SH    = 32 - FRAC_BITS;
  localparam logic [31:0] LIMIT = 32'(SHIFT_LIMIT) << FRAC_BITS;
  localparam logic [31:0] ONE   = 32'd1 << FRAC_BITS;

  localparam logic [4:0] S_IDLE  = 5'd0,  S_CHK   = 5'd1,  S_RDIV = 5'd2,
                         S_NORM  = 5'd3,  S_LSQ   = 5'd4,  S_LSQW = 5'd5,
                         S_LFR   = 5'd6,  S_LFRW  = 5'd7,  S_LINT = 5'd8,
                         S_LINTW = 5'd9,  S_HDIV  = 5'd10, S_RDV2 = 5'd11,
                         S_FSQ   = 5'd12, S_FSQW  = 5'd13, S_HM   = 5'd14,
                         S_HMW   = 5'd15, S_MAG   = 5'd16, S_OUT  = 5'd17;

  logic [4:0]         state;
  logic [31:0]        u;
  logic signed [63:0] acc;
  logic [31:0]        m;
  logic [4:0]         p;
  logic [31:0]        fr;
  logic [4:0]         rcnt;
  logic [31:0]        r;
  logic [31:0]        f;
  logic signed [33:0] t;
  logic [2:0]         kcnt;
  logic               inv;
  logic               neg;
  logic [63:0]        mag;

  // shared units
  logic [31:0]    mul_a, mul_b;
  logic [63:0]    prod;
  logic           div_start, div_half;
  logic [NW-1:0]  div_num, div_q;
  dgev_div_stat_t div_stat;

  dgev_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  dgev_div #(.NW(NW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(u),
    .quo(div_q), .stat(div_stat)
  );

  // derived values
  logic signed [6:0]  pf;
  logic [5:0]         pmag;
  logic [31:0]        tmag;
  logic [64:0]        prr;
  logic [31:0]        pr;
  logic signed [33:0] spr;
  logic [32:0]        mm;
  logic [63:0]        rnd;

  assign pf   = $signed({2'b00, p}) - 7'(FRAC_BITS);
  assign pmag = pf[6] ? 6'(-pf) : pf[5:0];
  assign tmag = t[33] ? 32'(-t) : t[31:0];
  assign prr  = 65'(prod) + 65'h8000_0000;
  assign pr   = prr[63:32];
  assign spr  = t[33] ? -$signed({2'b00, pr}) : $signed({2'b00, pr});
  assign mm   = prod[63:31];
  assign rnd  = (mag + (64'd1 << (SH - 1))) >> SH;

  // divider start and numerator
  assign div_start = (state == S_CHK && u <= LIMIT) || state == S_LINTW
                   || (state == S_HDIV && div_stat.done);
  assign div_half  = (state == S_LINTW);
  assign div_num   = (div_half ? (NW'(1) << (31 + FRAC_BITS))
                               : (NW'(1) << (32 + FRAC_BITS))) + NW'(u >> 1);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_LSQ:   begin mul_a = m;          mul_b = m;       end
      S_LFR:   begin mul_a = fr;         mul_b = LN2_Q32; end
      S_LINT:  begin mul_a = 32'(pmag);  mul_b = LN2_Q32; end
      S_FSQ:   begin mul_a = r;          mul_b = r;       end
      S_HM:    begin mul_a = tmag;       mul_b = f;       end
      default: begin mul_a = '0;         mul_b = '0;      end
    endcase
  end

  assign s_tready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // S_OUT drives m_tvalid itself
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          u   <= s_tdata;
          acc <= '0;
          mag <= '0;
          neg <= 1'b0;
          inv <= (s_tdata == '0);
          state <= (s_tdata == '0) ? S_OUT : S_CHK;
        end
        S_CHK: begin
          if (u <= LIMIT) state <= S_RDIV;
          else begin
            m     <= u;
            p     <= 5'd31;
            state <= S_NORM;
          end
        end
        S_RDIV: if (div_stat.done) begin
          acc   <= acc - $signed(64'(div_q));
          u     <= u + ONE;
          state <= S_CHK;
        end
        S_NORM: begin
          if (m[31]) begin
            rcnt  <= '0;
            fr    <= '0;
            state <= S_LSQ;
          end else begin
            m <= m << 1;
            p <= p - 1'b1;
          end
        end
        S_LSQ: state <= S_LSQW;
        // one log2 fraction bit per squaring
        S_LSQW: begin
          m     <= mm[32] ? mm[32:1] : mm[31:0];
          fr    <= {fr[30:0], mm[32]};
          rcnt  <= rcnt + 1'b1;
          state <= (rcnt == 5'd31) ? S_LFR : S_LSQ;
        end
        S_LFR:  state <= S_LFRW;
        S_LFRW: begin
          acc   <= acc + $signed(64'(prr[64:32]));
          state <= S_LINT;
        end
        S_LINT:  state <= S_LINTW;
        S_LINTW: begin
          acc   <= pf[6] ? acc - $signed(prod) : acc + $signed(prod);
          state <= S_HDIV;
        end
        S_HDIV: if (div_stat.done) begin
          acc   <= acc - $signed(64'(div_q));
          state <= S_RDV2;
        end
        S_RDV2: if (div_stat.done) begin
          r     <= div_q[31:0];
          state <= S_FSQ;
        end
        S_FSQ:  state <= S_FSQW;
        S_FSQW: begin
          f     <= pr;
          t     <= series_coef(3'd7);
          kcnt  <= 3'd7;
          state <= S_HM;
        end
        S_HM:  state <= S_HMW;
        // Horner step, last product goes to the accumulator
        S_HMW: begin
          if (kcnt != 3'd0) begin
            t     <= series_coef(kcnt - 1'b1) + spr;
            kcnt  <= kcnt - 1'b1;
            state <= S_HM;
          end else begin
            acc   <= acc + {{30{spr[33]}}, spr};
            state <= S_MAG;
          end
        end
        S_MAG: begin
          neg   <= acc[63];
          mag   <= acc[63] ? 64'(-acc) : 64'(acc);
          state <= S_OUT;
        end
        // round, clamp and load the output register
        S_OUT: if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
          if (inv) begin
            m_tdata <= '0;
            m_tuser <= 2'b10;
          end else if (neg) begin
            m_tdata <= (rnd > 64'h8000_0000) ? 32'h8000_0000 : 32'(-rnd);
            m_tuser <= {1'b0, rnd > 64'h8000_0000};
          end else begin
            m_tdata <= (rnd > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : rnd[31:0];
            m_tuser <= {1'b0, rnd > 64'h7FFF_FFFF};
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "digamma_evaluator_top_assert.svh"

  `DGEV_ASSERT_IMP(a_div_free, div_start, !div_stat.busy, "divider restarted while busy")
  `DGEV_ASSERT_NXT(a_leave_idle, s_tvalid && s_tready, state != S_IDLE, "accept did not start work")
  `DGEV_ASSERT_IMP(a_flag_excl, m_tvalid, !(m_tuser[0] && m_tuser[1]), "both flags set")
  `DGEV_ASSERT_IMP(a_inv_zero, m_tvalid && m_tuser[1], m_tdata == '0, "invalid result not zero")

endmodule
